// ===== src/pata_pio_device_registers_assert.svh =====
// Assertion macros shared by the register block RTL.
`ifndef PATA_PIO_DEVICE_REGISTERS_ASSERT_SVH
`define PATA_PIO_DEVICE_REGISTERS_ASSERT_SVH

// Same-cycle implication, sampled on clk with reset rst_n.
`define PPDR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, sampled on clk with reset rst_n.
`define PPDR_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== src/ppdr_pkg.sv =====
// Package with register offsets, command codes and status values of the task file.
`timescale 1ns / 1ps
package ppdr_pkg;

    // Register offsets of the command and control blocks.
    localparam logic [3:0] OFF_DATA    = 4'd0;
    localparam logic [3:0] OFF_ERROR   = 4'd1;
    localparam logic [3:0] OFF_COUNT   = 4'd2;
    localparam logic [3:0] OFF_LBA_LO  = 4'd3;
    localparam logic [3:0] OFF_LBA_MID = 4'd4;
    localparam logic [3:0] OFF_LBA_HI  = 4'd5;
    localparam logic [3:0] OFF_DEVICE  = 4'd6;
    localparam logic [3:0] OFF_STATUS  = 4'd7;
    localparam logic [3:0] OFF_ALT     = 4'd14;

    // Command codes.
    localparam logic [7:0] CMD_DIAG        = 8'h90;
    localparam logic [7:0] CMD_IDENTIFY    = 8'hEC;
    localparam logic [7:0] CMD_INIT_PARAMS = 8'h91;
    localparam logic [7:0] CMD_READ        = 8'h20;
    localparam logic [7:0] CMD_READ_NR     = 8'h21;
    localparam logic [7:0] CMD_WRITE       = 8'h30;
    localparam logic [7:0] CMD_WRITE_NR    = 8'h31;

    // Status and error values.
    localparam logic [7:0] ST_READY     = 8'h40;
    localparam logic [7:0] ST_DRQ       = 8'h08;
    localparam logic [7:0] ST_ERR       = 8'h41;
    localparam logic [7:0] ERR_ABORT    = 8'h04;
    localparam logic [7:0] ERR_DIAG_OK  = 8'h01;
    localparam logic [7:0] ERR_NO_MEDIA = 8'hFF;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TOTAL_SECTORS = 2'd0;
    localparam logic [1:0] CFG_MEDIA_PRESENT = 2'd1;
    localparam logic [1:0] CFG_SERIAL_LOW    = 2'd2;
    localparam logic [1:0] CFG_SERIAL_HIGH   = 2'd3;

    // Transfer index value that marks no transfer in progress.
    localparam logic [16:0] IDLE_INDEX = 17'h1FFFF;

    // Number of identify words written by the identify sequencer.
    localparam int IDENT_WORDS = 10;

    typedef logic [16:0] xfer_count_t;

    // Buffer word written at each identify step.
    function automatic logic [6:0] ident_addr(input logic [3:0] step);
        logic [6:0] a;
        case (step)
            4'd0:    a = 7'd10;
            4'd1:    a = 7'd11;
            4'd2:    a = 7'd12;
            4'd3:    a = 7'd13;
            4'd4:    a = 7'd14;
            4'd5:    a = 7'd60;
            4'd6:    a = 7'd61;
            4'd7:    a = 7'd100;
            4'd8:    a = 7'd101;
            default: a = 7'd102;
        endcase
        return a;
    endfunction

endpackage

// ===== src/pata_pio_device_registers.sv =====
// PATA device register block: task file, transfer buffer and sector store.
//
// Every word on the slave stream is one host register access: tuser carries
// the access kind and register offset, tdata the write value. Every accepted
// word yields exactly one word on the master stream: the read value, or zero
// for writes and unmapped offsets. Configuration (medium size, media flag,
// serial number) is written through the plain cfg write port.
// Plain register results go straight to the output register; a data port
// read first passes through S_RDATA, since the transfer buffer RAM returns
// its word in the cycle after the address. Read sectors copies the store into
// the buffer one word per cycle; the last data port write commits the buffer
// to the store at the same rate; identify fills its 10 words. These copies
// are bound by the single read port of each RAM. After reset the sector store
// is cleared one word per cycle, all 256 * DISK_SECTORS words (1048576 by
// default); s_tready stays low then.
// A result waits in the output register while m_tready is low; the next word
// is taken in the same cycle the waiting result leaves.
`timescale 1ns / 1ps
`include "pata_pio_device_registers_assert.svh"
module pata_pio_device_registers #(
    parameter int MAX_TRANSFER_SECTORS = 256,
    parameter int DISK_SECTORS         = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] write_data
    input  logic [4:0]  s_tuser,   // [0] cmd, [4:1] reg_offset
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] read_data
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import ppdr_pkg::*;

    localparam int BUF_WORDS   = MAX_TRANSFER_SECTORS * 256;
    localparam int BUF_AW      = $clog2(BUF_WORDS);
    localparam int STORE_WORDS = DISK_SECTORS * 256;
    localparam int STORE_AW    = $clog2(STORE_WORDS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RDATA,
        S_IDENT,
        S_FILL,
        S_COMMIT
    } state_t;

    state_t              state_reg;
    logic [12:0]         total_sectors_reg;
    logic                media_present_reg;
    logic [63:0]         serial_low_reg;
    logic [15:0]         serial_high_reg;
    logic [8:0]          sector_total_reg;
    logic [27:0]         block_address_reg;
    logic [7:0]          head_select_reg;
    logic [7:0]          status_reg;
    logic [7:0]          error_reg;
    xfer_count_t         xfer_index_reg;
    logic [BUF_AW-1:0]   buf_ptr_reg;
    xfer_count_t         cnt_reg;
    logic [BUF_AW-1:0]   cp_ptr_reg;
    logic [36:0]         cp_addr_reg;
    logic                pipe_v_reg;
    logic [BUF_AW-1:0]   pipe_ptr_reg;
    logic [36:0]         pipe_addr_reg;
    logic [STORE_AW-1:0] clr_addr_reg;
    logic                m_tvalid_reg;
    logic [15:0]         m_tdata_reg;

    logic                acc;
    logic                is_wr;
    logic [3:0]          off;
    logic [7:0]          wbyte;
    xfer_count_t         xfer_len;
    logic [16:0]         medium_sectors;
    logic                range_bad;
    logic                xfer_active;
    logic                data_rd;
    logic [15:0]         rd_val;
    logic [79:0]         serial_all;
    logic [15:0]         ident_word;
    logic [BUF_AW-1:0]   buf_ptr_next;
    logic [BUF_AW-1:0]   cp_ptr_next;

    logic                buf_we;
    logic [BUF_AW-1:0]   buf_waddr;
    logic [15:0]         buf_wdata;
    logic [BUF_AW-1:0]   buf_raddr;
    logic [15:0]         buf_rdata;
    logic                store_we;
    logic [STORE_AW-1:0] store_waddr;
    logic [15:0]         store_wdata;
    logic [STORE_AW-1:0] store_raddr;
    logic [15:0]         store_rdata;

    // Decode of the incoming word.
    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign acc      = s_tvalid && s_tready;
    assign is_wr    = s_tuser[0];
    assign off      = s_tuser[4:1];
    assign wbyte    = s_tdata[7:0];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Transfer length, medium size and range check.
    assign xfer_len    = {sector_total_reg, 8'd0};
    assign xfer_active = xfer_index_reg < xfer_len;
    assign data_rd     = acc && !is_wr && (off == OFF_DATA) && xfer_active;
    always_comb
    begin
        if (!media_present_reg)
        begin
            medium_sectors = '0;
        end
        else if (17'(total_sectors_reg) > 17'(DISK_SECTORS))
        begin
            medium_sectors = 17'(DISK_SECTORS);
        end
        else
        begin
            medium_sectors = 17'(total_sectors_reg);
        end
    end
    assign range_bad = (29'(block_address_reg) + 29'(sector_total_reg)) > 29'(medium_sectors);

    // Wrapping buffer pointers.
    assign buf_ptr_next = (buf_ptr_reg == BUF_AW'(BUF_WORDS - 1)) ? '0 : buf_ptr_reg + 1'b1;
    assign cp_ptr_next  = (cp_ptr_reg == BUF_AW'(BUF_WORDS - 1)) ? '0 : cp_ptr_reg + 1'b1;

    // Identify word for the current sequencer step.
    assign serial_all = {serial_high_reg, serial_low_reg};
    always_comb
    begin
        case (cnt_reg[3:0])
            4'd0:          ident_word = serial_all[15:0];
            4'd1:          ident_word = serial_all[31:16];
            4'd2:          ident_word = serial_all[47:32];
            4'd3:          ident_word = serial_all[63:48];
            4'd4:          ident_word = serial_all[79:64];
            4'd5, 4'd7:    ident_word = medium_sectors[15:0];
            4'd6, 4'd8:    ident_word = {15'd0, medium_sectors[16]};
            default:       ident_word = '0;
        endcase
    end

    // Register read values other than the data port.
    always_comb
    begin
        case (off)
            OFF_ERROR:          rd_val = {8'd0, error_reg};
            OFF_COUNT:          rd_val = {8'd0, sector_total_reg[7:0]};
            OFF_LBA_LO:         rd_val = {8'd0, block_address_reg[7:0]};
            OFF_LBA_MID:        rd_val = {8'd0, block_address_reg[15:8]};
            OFF_LBA_HI:         rd_val = {8'd0, block_address_reg[23:16]};
            OFF_DEVICE:         rd_val = {8'd0, head_select_reg};
            OFF_STATUS, OFF_ALT: rd_val = {8'd0, status_reg};
            default:            rd_val = '0;
        endcase
    end

    // Memory port steering.
    always_comb
    begin
        buf_we      = 1'b0;
        buf_waddr   = buf_ptr_reg;
        buf_wdata   = s_tdata;
        buf_raddr   = buf_ptr_reg;
        store_we    = 1'b0;
        store_waddr = pipe_addr_reg[STORE_AW-1:0];
        store_wdata = buf_rdata;
        store_raddr = cp_addr_reg[STORE_AW-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                store_we    = 1'b1;
                store_waddr = clr_addr_reg;
                store_wdata = '0;
            end
            S_IDLE:
            begin
                buf_we = acc && is_wr && (off == OFF_DATA) && xfer_active;
            end
            S_IDENT:
            begin
                buf_we    = 1'b1;
                buf_waddr = BUF_AW'(ident_addr(cnt_reg[3:0]));
                buf_wdata = ident_word;
            end
            S_FILL:
            begin
                buf_we    = pipe_v_reg;
                buf_waddr = pipe_ptr_reg;
                buf_wdata = store_rdata;
            end
            S_COMMIT:
            begin
                buf_raddr = cp_ptr_reg;
                store_we  = pipe_v_reg && (pipe_addr_reg < 37'(STORE_WORDS));
            end
            default:
            begin
                buf_we = 1'b0;
            end
        endcase
    end

    // Sequencer, task file and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            total_sectors_reg <= '0;
            media_present_reg <= 1'b0;
            serial_low_reg    <= '0;
            serial_high_reg   <= '0;
            sector_total_reg  <= 9'd1;
            block_address_reg <= 28'd1;
            head_select_reg   <= '0;
            status_reg        <= ST_READY;
            error_reg         <= ERR_DIAG_OK;
            xfer_index_reg    <= IDLE_INDEX;
            buf_ptr_reg       <= '0;
            cnt_reg           <= '0;
            cp_ptr_reg        <= '0;
            cp_addr_reg       <= '0;
            pipe_v_reg        <= 1'b0;
            pipe_ptr_reg      <= '0;
            pipe_addr_reg     <= '0;
            clr_addr_reg      <= '0;
            m_tvalid_reg      <= 1'b0;
            m_tdata_reg       <= '0;
        end
        else
        begin
            // Configuration writes.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TOTAL_SECTORS: total_sectors_reg <= cfg_data[12:0];
                    CFG_MEDIA_PRESENT: media_present_reg <= cfg_data[0];
                    CFG_SERIAL_LOW:    serial_low_reg    <= cfg_data;
                    CFG_SERIAL_HIGH:   serial_high_reg   <= cfg_data[15:0];
                    default:           serial_high_reg   <= serial_high_reg;
                endcase
            end

            // The output word leaves when taken, unless a new one replaces it.
            if (m_tvalid_reg && m_tready && !(acc && !data_rd))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == STORE_AW'(STORE_WORDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (acc)
                    begin
                        if (!data_rd)
                        begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= is_wr ? 16'd0 : rd_val;
                        end
                        if (!is_wr)
                        begin
                            // Data port read: word arrives from the buffer next cycle.
                            if (off == OFF_DATA && xfer_active)
                            begin
                                if (xfer_index_reg == xfer_len - 1'b1)
                                begin
                                    status_reg <= ST_READY;
                                end
                                xfer_index_reg <= xfer_index_reg + 1'b1;
                                buf_ptr_reg    <= buf_ptr_next;
                                state_reg      <= S_RDATA;
                            end
                        end
                        else
                        begin
                            case (off)
                                OFF_DATA:
                                begin
                                    if (xfer_active)
                                    begin
                                        xfer_index_reg <= xfer_index_reg + 1'b1;
                                        buf_ptr_reg    <= buf_ptr_next;
                                        if (xfer_index_reg + 1'b1 == xfer_len)
                                        begin
                                            status_reg  <= ST_READY;
                                            cnt_reg     <= '0;
                                            cp_ptr_reg  <= '0;
                                            cp_addr_reg <= {1'b0, block_address_reg, 8'd0};
                                            pipe_v_reg  <= 1'b0;
                                            state_reg   <= S_COMMIT;
                                        end
                                    end
                                end
                                OFF_COUNT:
                                begin
                                    sector_total_reg <= (wbyte == 8'd0) ? 9'd256 : {1'b0, wbyte};
                                end
                                OFF_LBA_LO:  block_address_reg[7:0]   <= wbyte;
                                OFF_LBA_MID: block_address_reg[15:8]  <= wbyte;
                                OFF_LBA_HI:  block_address_reg[23:16] <= wbyte;
                                OFF_DEVICE:
                                begin
                                    block_address_reg[27:24] <= wbyte[3:0];
                                    head_select_reg          <= wbyte;
                                end
                                OFF_STATUS:
                                begin
                                    case (wbyte)
                                        CMD_DIAG:
                                        begin
                                            sector_total_reg  <= 9'd1;
                                            block_address_reg <= 28'd1;
                                            status_reg        <= ST_READY;
                                            error_reg         <= media_present_reg ?
                                                                 ERR_DIAG_OK : ERR_NO_MEDIA;
                                            head_select_reg   <= '0;
                                        end
                                        CMD_IDENTIFY:
                                        begin
                                            status_reg     <= ST_DRQ;
                                            xfer_index_reg <= '0;
                                            buf_ptr_reg    <= '0;
                                            cnt_reg        <= '0;
                                            state_reg      <= S_IDENT;
                                        end
                                        CMD_INIT_PARAMS:
                                        begin
                                            status_reg <= ST_READY;
                                        end
                                        CMD_READ, CMD_READ_NR:
                                        begin
                                            if (range_bad)
                                            begin
                                                status_reg <= ST_ERR;
                                                error_reg  <= ERR_ABORT;
                                            end
                                            else
                                            begin
                                                status_reg     <= ST_DRQ;
                                                xfer_index_reg <= '0;
                                                buf_ptr_reg    <= '0;
                                                cnt_reg        <= '0;
                                                cp_ptr_reg     <= '0;
                                                cp_addr_reg    <= {1'b0, block_address_reg, 8'd0};
                                                pipe_v_reg     <= 1'b0;
                                                state_reg      <= S_FILL;
                                            end
                                        end
                                        CMD_WRITE, CMD_WRITE_NR:
                                        begin
                                            if (range_bad)
                                            begin
                                                status_reg <= ST_ERR;
                                                error_reg  <= ERR_ABORT;
                                            end
                                            else
                                            begin
                                                status_reg     <= ST_DRQ;
                                                xfer_index_reg <= '0;
                                                buf_ptr_reg    <= '0;
                                            end
                                        end
                                        default:
                                        begin
                                            status_reg <= status_reg;
                                        end
                                    endcase
                                end
                                default:
                                begin
                                    status_reg <= status_reg;
                                end
                            endcase
                        end
                    end
                end

                S_RDATA:
                begin
                    m_tvalid_reg <= 1'b1;
                    m_tdata_reg  <= buf_rdata;
                    state_reg    <= S_IDLE;
                end

                S_IDENT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 17'(IDENT_WORDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_FILL, S_COMMIT:
                begin
                    // One word per cycle: read one RAM, write the other in the next cycle.
                    if (cnt_reg < xfer_len)
                    begin
                        pipe_v_reg    <= 1'b1;
                        pipe_ptr_reg  <= cp_ptr_reg;
                        pipe_addr_reg <= cp_addr_reg;
                        cnt_reg       <= cnt_reg + 1'b1;
                        cp_ptr_reg    <= cp_ptr_next;
                        cp_addr_reg   <= cp_addr_reg + 1'b1;
                    end
                    else
                    begin
                        pipe_v_reg <= 1'b0;
                        if (!pipe_v_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Transfer buffer.
    ppdr_ram #(
        .WIDTH (16),
        .DEPTH (BUF_WORDS)
    ) u_buf_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    // Sector store.
    ppdr_ram #(
        .WIDTH (16),
        .DEPTH (STORE_WORDS)
    ) u_store_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // A data port read with a transfer active waits in S_RDATA for the buffer word.
    `PPDR_ASSERT_NXT(a_rdata_result, data_rd, !m_tvalid_reg && state_reg == S_RDATA)
    // No host word is taken while the store is being cleared.
    `PPDR_ASSERT_IMP(a_no_accept_in_clear, state_reg == S_CLEAR, !s_tready)
    // The store is written only by the clearing pass or a commit.
    `PPDR_ASSERT_IMP(a_store_write_src, store_we, state_reg == S_CLEAR || state_reg == S_COMMIT)

endmodule

// ===== src/ppdr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module ppdr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
